/* design/electronic_differential_pedal_map_defines.svh */
// assertion macros for the electronic differential pedal map
`ifndef ELECTRONIC_DIFFERENTIAL_PEDAL_MAP_DEFINES_SVH
`define ELECTRONIC_DIFFERENTIAL_PEDAL_MAP_DEFINES_SVH
`ifndef SYNTH
`define EDPM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("edpm check");
`define EDPM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("edpm check");
`else
`define EDPM_ASSERT(label, clk, rst_n, prop)
`define EDPM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* design/edpm_pkg.sv */
// shared types and constants for the electronic differential pedal map
`timescale 1ns / 1ps
`default_nettype none
package edpm_pkg;
  typedef enum logic [2:0] {
    REG_PEDAL_MIN_OFFSET = 3'd0,
    REG_PEDAL_FULL_SCALE = 3'd1,
    REG_PEDAL_FULL_SCALE_TURNING = 3'd2,
    REG_TURN_THRESHOLD = 3'd3,
    REG_STEER_DEAD_ZONE = 3'd4,
    REG_TRACK_WHEELBASE_RATIO = 3'd5,
    REG_STEERING_CENTER_RAW = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_HIST, ST_AVG, ST_ANGLE, ST_THR_MUL, ST_THR_DIV,
    ST_TAN, ST_DIFF1, ST_DIFF2, ST_OUT, ST_WHEEL
  } state_t;

  localparam logic [15:0] PEDAL_MARGIN = 16'd200;
  localparam logic [16:0] ANGLE_GAIN_Q16 = 17'd116695;
  localparam logic [14:0] ANGLE_LIMIT = 15'd22877;
  localparam int TAN_STEP_SHIFT = 9;
  localparam logic [3:0] TAN_LAST = 4'd12;

  function automatic logic [14:0] tan_entry(input logic [3:0] i);
    case (i)
      4'd0: tan_entry = 15'd0;
      4'd1: tan_entry = 15'd2049;
      4'd2: tan_entry = 15'd4101;
      4'd3: tan_entry = 15'd6162;
      4'd4: tan_entry = 15'd8235;
      4'd5: tan_entry = 15'd10324;
      4'd6: tan_entry = 15'd12434;
      4'd7: tan_entry = 15'd14569;
      4'd8: tan_entry = 15'd16734;
      4'd9: tan_entry = 15'd18934;
      4'd10: tan_entry = 15'd21174;
      4'd11: tan_entry = 15'd23459;
      default: tan_entry = 15'd25797;
    endcase
  endfunction
endpackage
`default_nettype wire

/* design/edpm_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module edpm_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [16:0] trial;
  logic [17:0] diff;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial = {rem_r[15:0], q_r[31]};
    diff = {1'b0, trial} - {2'b00, dvs_r};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!diff[17]) begin
        rem_nxt = diff[16:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = start || (cnt_r != 6'd0);
  assign quotient = q_r;
endmodule
`default_nettype wire

/* design/edpm_history.sv */
// pedal history ring with running sum, cleared by a sweep after reset
`timescale 1ns / 1ps
`default_nettype none
module edpm_history #(
  parameter int AVERAGE_LENGTH = 10,
  parameter int SUM_W = 22
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             upd,
  input  wire logic [15:0]      pedal,
  output logic                  clearing,
  output logic [SUM_W-1:0]      sum
);
  localparam int SLOT_W = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(AVERAGE_LENGTH - 1);

  logic [15:0] hist_r [AVERAGE_LENGTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic clr_r, clr_nxt;

  always_comb begin
    slot_nxt = slot_r;
    sum_nxt = sum_r;
    clr_nxt = clr_r;
    if (clr_r) begin
      slot_nxt = (slot_r == LAST) ? '0 : slot_r + 1'b1;
      if (slot_r == LAST) clr_nxt = 1'b0;
    end else if (upd) begin
      sum_nxt = sum_r - SUM_W'(hist_r[slot_r]) + SUM_W'(pedal);
      slot_nxt = (slot_r == LAST) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      sum_r <= '0;
      clr_r <= 1'b1;
    end else begin
      slot_r <= slot_nxt;
      sum_r <= sum_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_r) begin
      hist_r[slot_r] <= '0;
    end else if (upd) begin
      hist_r[slot_r] <= pedal;
    end
  end

  assign clearing = clr_r || !rst_n;
  assign sum = sum_nxt;
endmodule
`default_nettype wire

/* design/electronic_differential_pedal_map.sv */
// electronic differential pedal map: top level, sequencer and shared multiplier
// a beat steps through the sequencer states; the serial divide is skipped when the throttle
// is forced to zero or full scale; one item at a time, one 32x32 multiplier, one serial divider
// in_stall is high until the result registers; a waiting result beat holds the next item
// reset is synchronous and active low; control and configuration registers take reset values
// and the pedal history is then cleared slot by slot before the first beat is taken
`timescale 1ns / 1ps
`default_nettype none
`include "electronic_differential_pedal_map_defines.svh"
module electronic_differential_pedal_map #(
  parameter int AVERAGE_LENGTH = 10,
  parameter int STEER_LOCK_DIVISOR = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        in_pedal_sample,
  input  wire logic [15:0]        in_steering_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_throttle_command,
  output logic [16:0]             out_outer_wheel_speed,
  output logic [15:0]             out_inner_wheel_speed,
  output logic signed [15:0]      out_steering_angle,
  output logic signed [13:0]      out_wheel_angle,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  localparam int SUM_W = 16 + $clog2(AVERAGE_LENGTH + 1);
  // reciprocal constants for division by the average length and the steering lock divisor
  localparam int AVG_SHIFT = SUM_W + 6;
  localparam logic [31:0] AVG_RECIP = 32'(((64'd1 << AVG_SHIFT) + 64'(AVERAGE_LENGTH)
                                           - 64'd1) / 64'(AVERAGE_LENGTH));
  localparam int LOCK_SHIFT = 20;
  localparam logic [31:0] LOCK_RECIP = 32'(((64'd1 << LOCK_SHIFT) + 64'(STEER_LOCK_DIVISOR)
                                            - 64'd1) / 64'(STEER_LOCK_DIVISOR));

  logic [15:0] offset_r, fs_r, fst_r, ratio_r, center_r;
  logic [14:0] thr_r, dz_r;

  edpm_pkg::state_t st_r, st_nxt;
  logic [15:0] steer_r;
  logic [15:0] pedal_r;
  logic [31:0] avg_r, avg_nxt;
  logic [14:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] thr_cmd_r, thr_cmd_nxt;
  logic [14:0] wmag_r, wmag_nxt;
  logic [15:0] tan_r, tan_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] half_r, half_nxt;
  logic        ovf_r, ovf_nxt;
  logic        ov_r, ov_nxt;

  logic        hist_upd, clearing;
  logic [SUM_W-1:0] hsum;
  logic        div_start, div_busy;
  logic [31:0] div_dvd, div_q;
  logic [15:0] div_dvs;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [15:0] fs_sel;
  logic [16:0] dmag;
  logic [16:0] offm;
  logic [3:0]  ti;
  logic [8:0]  tf;
  logic [14:0] t0, t1;
  logic [24:0] interp;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  edpm_history #(.AVERAGE_LENGTH(AVERAGE_LENGTH), .SUM_W(SUM_W)) u_hist (
    .clk(clk), .rst_n(rst_n), .upd(hist_upd), .pedal(pedal_r),
    .clearing(clearing), .sum(hsum)
  );

  edpm_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .busy(div_busy), .quotient(div_q)
  );

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 16'd6650;
      fs_r <= 16'd65535;
      fst_r <= 16'd58500;
      thr_r <= 15'd1638;
      dz_r <= 15'd655;
      ratio_r <= 16'd42975;
      center_r <= 16'd35639;
    end else if (cfg_valid) begin
      case (cfg_index)
        edpm_pkg::REG_PEDAL_MIN_OFFSET: offset_r <= cfg_data;
        edpm_pkg::REG_PEDAL_FULL_SCALE: fs_r <= cfg_data;
        edpm_pkg::REG_PEDAL_FULL_SCALE_TURNING: fst_r <= cfg_data;
        edpm_pkg::REG_TURN_THRESHOLD: thr_r <= cfg_data[14:0];
        edpm_pkg::REG_STEER_DEAD_ZONE: dz_r <= cfg_data[14:0];
        edpm_pkg::REG_TRACK_WHEELBASE_RATIO: ratio_r <= cfg_data;
        edpm_pkg::REG_STEERING_CENTER_RAW: center_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (st_r != edpm_pkg::ST_IDLE) || clearing;
  assign out_valid = ov_r;

  always_comb begin
    st_nxt = st_r;
    avg_nxt = avg_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    thr_cmd_nxt = thr_cmd_r;
    wmag_nxt = wmag_r;
    tan_nxt = tan_r;
    prod_nxt = prod_r;
    half_nxt = half_r;
    ovf_nxt = ovf_r;
    ov_nxt = ov_r;
    hist_upd = 1'b0;
    div_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    fs_sel = (mag_r >= thr_r) ? fst_r : fs_r;
    div_dvd = prod_r[31:0];
    div_dvs = fs_sel;
    dmag = (steer_r < center_r) ? 17'(center_r - steer_r) : 17'(steer_r - center_r);
    offm = 17'(offset_r) + 17'(edpm_pkg::PEDAL_MARGIN);
    ti = (wmag_r[14:9] >= 6'(edpm_pkg::TAN_LAST)) ? edpm_pkg::TAN_LAST : wmag_r[12:9];
    tf = wmag_r[8:0];
    t0 = edpm_pkg::tan_entry(ti);
    t1 = edpm_pkg::tan_entry((ti == edpm_pkg::TAN_LAST) ? ti : ti + 4'd1);
    interp = 25'(t1 - t0) * 25'(tf) + 25'd256;
    case (st_r)
      edpm_pkg::ST_IDLE: begin
        if (out_valid && !out_stall) ov_nxt = 1'b0;
        if (in_valid && !in_stall) st_nxt = edpm_pkg::ST_HIST;
      end
      edpm_pkg::ST_HIST: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b0;
          hist_upd = 1'b1;
          st_nxt = edpm_pkg::ST_ANGLE;
        end
      end
      edpm_pkg::ST_ANGLE: begin
        mul_a = 32'(dmag);
        mul_b = 32'(edpm_pkg::ANGLE_GAIN_Q16);
        prod_nxt = mul_p + 64'd32768;
        neg_nxt = steer_r < center_r;
        st_nxt = edpm_pkg::ST_AVG;
      end
      edpm_pkg::ST_AVG: begin
        if (prod_r[63:16] > 48'(edpm_pkg::ANGLE_LIMIT)) mag_nxt = edpm_pkg::ANGLE_LIMIT;
        else mag_nxt = prod_r[30:16];
        mul_a = 32'(hsum);
        mul_b = AVG_RECIP;
        avg_nxt = 32'(mul_p >> AVG_SHIFT);
        st_nxt = edpm_pkg::ST_WHEEL;
      end
      edpm_pkg::ST_WHEEL: begin
        mul_a = 32'(mag_r);
        mul_b = LOCK_RECIP;
        wmag_nxt = (mag_r < dz_r) ? '0 : 15'(mul_p >> LOCK_SHIFT);
        st_nxt = edpm_pkg::ST_THR_MUL;
      end
      edpm_pkg::ST_THR_MUL: begin
        if (mag_r == '0) neg_nxt = 1'b0;
        mul_a = avg_r - 32'(offset_r);
        mul_b = 32'(fs_sel) + 32'(offset_r);
        prod_nxt = mul_p;
        if (avg_r < 32'(offm)) begin
          thr_cmd_nxt = '0;
          st_nxt = edpm_pkg::ST_TAN;
        end else if (fs_sel == '0) begin
          thr_cmd_nxt = 16'hffff;
          st_nxt = edpm_pkg::ST_TAN;
        end else begin
          st_nxt = edpm_pkg::ST_THR_DIV;
        end
      end
      edpm_pkg::ST_THR_DIV: begin
        // product is below 2^33; divide the low word, a nonzero high word saturates
        ovf_nxt = prod_r[63:32] != '0;
        div_start = 1'b1;
        st_nxt = edpm_pkg::ST_DIFF1;
      end
      edpm_pkg::ST_DIFF1: begin
        if (!div_busy) begin
          if (ovf_r || div_q[31:16] != '0) thr_cmd_nxt = 16'hffff;
          else thr_cmd_nxt = div_q[15:0];
          st_nxt = edpm_pkg::ST_TAN;
        end
      end
      edpm_pkg::ST_TAN: begin
        tan_nxt = 16'(t0) + ((ti == edpm_pkg::TAN_LAST) ? 16'd0 : 16'(interp[24:9]));
        st_nxt = edpm_pkg::ST_DIFF2;
      end
      edpm_pkg::ST_DIFF2: begin
        mul_a = 32'(tan_r);
        mul_b = 32'(ratio_r);
        prod_nxt = mul_p;
        st_nxt = edpm_pkg::ST_OUT;
      end
      edpm_pkg::ST_OUT: begin
        mul_a = prod_r[31:0];
        mul_b = 32'(thr_cmd_r);
        half_nxt = 32'((mul_p + 64'h1_0000_0000) >> 33);
        ov_nxt = 1'b1;
        st_nxt = edpm_pkg::ST_IDLE;
      end
      default: st_nxt = edpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= edpm_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    if (in_valid && !in_stall) begin
      pedal_r <= in_pedal_sample;
      steer_r <= in_steering_sample;
    end
    avg_r <= avg_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    thr_cmd_r <= thr_cmd_nxt;
    wmag_r <= wmag_nxt;
    tan_r <= tan_nxt;
    prod_r <= prod_nxt;
    half_r <= half_nxt;
    ovf_r <= ovf_nxt;
  end

  logic [16:0] outer_w;
  logic [15:0] inner_w;
  assign outer_w = 17'(thr_cmd_r) + half_r[16:0];
  assign inner_w = thr_cmd_r - half_r[15:0];

  assign out_throttle_command = thr_cmd_r;
  assign out_outer_wheel_speed = outer_w;
  assign out_inner_wheel_speed = inner_w;
  assign out_steering_angle = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign out_wheel_angle = (neg_r && wmag_r != '0) ? 14'(-{1'b0, wmag_r}) : wmag_r[13:0];

  `EDPM_ASSERT(a_busy_stall, clk, rst_n, (st_r != edpm_pkg::ST_IDLE) |-> in_stall)
  `EDPM_ASSERT(a_out_done, clk, rst_n, $rose(ov_r) |-> $past(st_r) == edpm_pkg::ST_OUT)
  `EDPM_ASSERT(a_inner_le, clk, rst_n, ov_r |-> (half_r[16:0] <= 17'(thr_cmd_r)))
endmodule
`default_nettype wire

/* test/testbench.sv */
// self-checking testbench for the electronic differential pedal map
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int AVG_LEN = 10;
  localparam int LOCK_DIV = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] throttle;
    logic [16:0] outer;
    logic [15:0] inner;
    logic [15:0] steer_angle;
    logic [13:0] wheel_angle;
  } wheel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_pedal_sample = '0;
  logic [15:0] in_steering_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_throttle_command;
  logic [16:0] out_outer_wheel_speed;
  logic [15:0] out_inner_wheel_speed;
  logic signed [15:0] out_steering_angle;
  logic signed [13:0] out_wheel_angle;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #10 clk = ~clk;

  electronic_differential_pedal_map dut (.*);

  // predictor state
  logic [15:0] pedal_ring [AVG_LEN];
  int unsigned ring_slot;
  int unsigned ring_sum;
  logic [15:0] offset_reg, fs_straight_reg, fs_turn_reg, ratio_reg, center_reg;
  logic [14:0] turn_thr_reg, dead_zone_reg;

  wheel_result_t expected_results [$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit burst_mode = 1'b1;

  function automatic int unsigned tan_lookup(int unsigned mag);
    int unsigned tab [13] = '{0, 2049, 4101, 6162, 8235, 10324, 12434, 14569, 16734,
                              18934, 21174, 23459, 25797};
    int unsigned i;
    int unsigned frac;
    i = mag >> 9;
    frac = mag & 511;
    if (i >= 12) return tab[12];
    return tab[i] + (((tab[i + 1] - tab[i]) * frac + 256) >> 9);
  endfunction

  function automatic wheel_result_t predict_wheels(logic [15:0] pedal, logic [15:0] steer);
    wheel_result_t r;
    int unsigned avg, mag, wmag, thr, fs, half;
    longint unsigned t;
    bit neg;
    ring_sum = ring_sum - pedal_ring[ring_slot] + pedal;
    pedal_ring[ring_slot] = pedal;
    ring_slot = (ring_slot + 1) % AVG_LEN;
    avg = ring_sum / AVG_LEN;
    neg = steer < center_reg;
    mag = neg ? center_reg - steer : steer - center_reg;
    t = (longint'(mag) * 116695 + 32768) >> 16;
    mag = (t > 22877) ? 22877 : int'(t);
    if (mag == 0) neg = 1'b0;
    if (avg < int'(offset_reg) + 200) begin
      thr = 0;
    end else begin
      fs = (mag >= turn_thr_reg) ? fs_turn_reg : fs_straight_reg;
      if (fs == 0) begin
        thr = 65535;
      end else begin
        t = longint'(avg - offset_reg) * longint'(fs + offset_reg) / fs;
        thr = (t > 65535) ? 65535 : int'(t);
      end
    end
    wmag = (mag < dead_zone_reg) ? 0 : mag / LOCK_DIV;
    t = longint'(tan_lookup(wmag)) * ratio_reg * thr;
    half = int'((t + 64'h1_0000_0000) >> 33);
    r.throttle = thr[15:0];
    r.outer = 17'(thr + half);
    r.inner = 16'(thr - half);
    r.steer_angle = neg ? 16'(-mag) : 16'(mag);
    r.wheel_angle = (neg && wmag != 0) ? 14'(-wmag) : 14'(wmag);
    return r;
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < AVG_LEN; i++) pedal_ring[i] = '0;
    ring_slot = 0;
    ring_sum = 0;
    offset_reg = 16'd6650;
    fs_straight_reg = 16'd65535;
    fs_turn_reg = 16'd58500;
    turn_thr_reg = 15'd1638;
    dead_zone_reg = 15'd655;
    ratio_reg = 16'd42975;
    center_reg = 16'd35639;
  endtask

  task automatic write_reg(edpm_pkg::reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      edpm_pkg::REG_PEDAL_MIN_OFFSET: offset_reg = value;
      edpm_pkg::REG_PEDAL_FULL_SCALE: fs_straight_reg = value;
      edpm_pkg::REG_PEDAL_FULL_SCALE_TURNING: fs_turn_reg = value;
      edpm_pkg::REG_TURN_THRESHOLD: turn_thr_reg = value[14:0];
      edpm_pkg::REG_STEER_DEAD_ZONE: dead_zone_reg = value[14:0];
      edpm_pkg::REG_TRACK_WHEELBASE_RATIO: ratio_reg = value;
      edpm_pkg::REG_STEERING_CENTER_RAW: center_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_beat(logic [15:0] pedal, logic [15:0] steer);
    int gap;
    if (burst_mode && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pedal_sample <= pedal;
    in_steering_sample <= steer;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_wheels(pedal, steer));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] steer_for_angle(int angle);
    int raw;
    raw = int'(center_reg) + (angle * 65536) / 116695;
    if (raw < 0) raw = 0;
    if (raw > 65535) raw = 65535;
    return raw[15:0];
  endfunction

  task automatic test_directed();
    send_beat(16'h0000, 16'h0000);
    send_beat(16'hffff, 16'hffff);
    for (int i = 0; i < 8; i++) send_beat(16'hffff, center_reg);
    send_beat(16'hffff, steer_for_angle(int'(turn_thr_reg)));
    send_beat(16'hffff, steer_for_angle(-int'(turn_thr_reg)));
    send_beat(16'hffff, steer_for_angle(int'(dead_zone_reg)));
    send_beat(16'hffff, steer_for_angle(int'(dead_zone_reg) - 4));
    send_beat(16'h0000, 16'hffff);
    send_beat(16'h8000, 16'h0000);
    send_beat(16'haaaa, 16'h5555);
    send_beat(16'h5555, 16'haaaa);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(edpm_pkg::REG_PEDAL_MIN_OFFSET, 16'd0);
    write_reg(edpm_pkg::REG_PEDAL_FULL_SCALE, 16'd0);
    write_reg(edpm_pkg::REG_PEDAL_FULL_SCALE_TURNING, 16'd0);
    write_reg(edpm_pkg::REG_TURN_THRESHOLD, 16'h7fff);
    write_reg(edpm_pkg::REG_STEER_DEAD_ZONE, 16'd0);
    write_reg(edpm_pkg::REG_TRACK_WHEELBASE_RATIO, 16'hffff);
    write_reg(edpm_pkg::REG_STEERING_CENTER_RAW, 16'd0);
    for (int i = 0; i < 12; i++) send_beat(16'hffff, 16'($urandom));
    drain();
    write_reg(edpm_pkg::REG_PEDAL_FULL_SCALE, 16'd1);
    write_reg(edpm_pkg::REG_PEDAL_FULL_SCALE_TURNING, 16'hffff);
    write_reg(edpm_pkg::REG_TURN_THRESHOLD, 16'd0);
    write_reg(edpm_pkg::REG_STEERING_CENTER_RAW, 16'hffff);
    for (int i = 0; i < 12; i++) send_beat(16'($urandom), 16'($urandom));
    drain();
    write_reg(edpm_pkg::REG_PEDAL_MIN_OFFSET, 16'hffff);
    write_reg(edpm_pkg::REG_STEER_DEAD_ZONE, 16'h7fff);
    write_reg(edpm_pkg::REG_TRACK_WHEELBASE_RATIO, 16'd0);
    for (int i = 0; i < 12; i++) send_beat(16'hffff, 16'($urandom));
    drain();
  endtask

  task automatic random_regs();
    write_reg(edpm_pkg::REG_PEDAL_MIN_OFFSET, 16'($urandom_range(0, 20000)));
    write_reg(edpm_pkg::REG_PEDAL_FULL_SCALE, 16'($urandom_range(0, 65535)));
    write_reg(edpm_pkg::REG_PEDAL_FULL_SCALE_TURNING, 16'($urandom_range(0, 65535)));
    write_reg(edpm_pkg::REG_TURN_THRESHOLD, 16'($urandom_range(0, 22877)));
    write_reg(edpm_pkg::REG_STEER_DEAD_ZONE, 16'($urandom_range(0, 22877)));
    write_reg(edpm_pkg::REG_TRACK_WHEELBASE_RATIO, 16'($urandom));
    write_reg(edpm_pkg::REG_STEERING_CENTER_RAW, 16'($urandom));
  endtask

  task automatic reset_regs_to_defaults();
    write_reg(edpm_pkg::REG_PEDAL_MIN_OFFSET, 16'd6650);
    write_reg(edpm_pkg::REG_PEDAL_FULL_SCALE, 16'd65535);
    write_reg(edpm_pkg::REG_PEDAL_FULL_SCALE_TURNING, 16'd58500);
    write_reg(edpm_pkg::REG_TURN_THRESHOLD, 16'd1638);
    write_reg(edpm_pkg::REG_STEER_DEAD_ZONE, 16'd655);
    write_reg(edpm_pkg::REG_TRACK_WHEELBASE_RATIO, 16'd42975);
    write_reg(edpm_pkg::REG_STEERING_CENTER_RAW, 16'd35639);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        reset_regs_to_defaults();
      end else begin
        random_regs();
      end
      burst_mode = (phase != 2);
      for (int i = 0; i < 105; i++) begin
        case ($urandom_range(0, 3))
          0: send_beat(16'($urandom), 16'($urandom));
          1: send_beat(16'($urandom_range(int'(offset_reg), 65535)),
                       steer_for_angle($urandom_range(0, 46000) - 23000));
          2: send_beat(16'($urandom_range(60000, 65535)),
                       16'(int'(center_reg) + $urandom_range(0, 800) - 400));
          default: send_beat(16'($urandom), 16'($urandom_range(0, 65535)));
        endcase
      end
      drain();
    end
    burst_mode = 1'b1;
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_beat(16'($urandom), 16'($urandom));
    drain();
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else begin
        hold = $urandom_range(0, 9);
        out_stall <= (hold < 3) && (beats_sent % 150 > 40);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    wheel_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_throttle_command !== exp_r.throttle) begin
          $error("throttle_command expected %0d got %0d", exp_r.throttle, out_throttle_command);
          errors++;
        end
        if (out_outer_wheel_speed !== exp_r.outer) begin
          $error("outer_wheel_speed expected %0d got %0d", exp_r.outer,
                 out_outer_wheel_speed);
          errors++;
        end
        if (out_inner_wheel_speed !== exp_r.inner) begin
          $error("inner_wheel_speed expected %0d got %0d", exp_r.inner,
                 out_inner_wheel_speed);
          errors++;
        end
        if (out_steering_angle !== exp_r.steer_angle) begin
          $error("steering_angle expected %0d got %0d", $signed(exp_r.steer_angle),
                 out_steering_angle);
          errors++;
        end
        if (out_wheel_angle !== exp_r.wheel_angle) begin
          $error("wheel_angle expected %0d got %0d", $signed(exp_r.wheel_angle),
                 out_wheel_angle);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or register write while work is pending
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || expected_results.size() == 0 && !in_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("sent %0d beats, checked %0d results over directed, extreme-register,",
             beats_sent, beats_checked);
    $display("backpressure and random-register phases");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+design
design/edpm_pkg.sv
design/edpm_divider.sv
design/edpm_history.sv
design/electronic_differential_pedal_map.sv
test/testbench.sv
